// ===== rtl/ppid_pkg.sv =====
// ----------------------------------------------------------------------------
// Positional PID package
// Shared widths, register indexes, datapath operations and the command bundle
// passed from the sequencer to the datapath.
// ----------------------------------------------------------------------------
package ppid_pkg;

   localparam int DATA_W        = 32;
   localparam int CLAMP_W       = 31;
   localparam int TIME_W        = 16;
   localparam int PERIOD_BITS   = 16;
   localparam int FRAC_BITS_DEF = 16;
   localparam int OPER_W        = DATA_W + 1;
   localparam int PROD_W        = 2 * OPER_W;
   localparam int CSR_ADDR_W    = 3;

   typedef enum logic [CSR_ADDR_W-1:0] {
      REG_PROP_GAIN     = 3'd0,
      REG_INTEG_GAIN    = 3'd1,
      REG_DERIV_GAIN    = 3'd2,
      REG_INTEG_CLAMP   = 3'd3,
      REG_SAMPLE_PERIOD = 3'd4,
      REG_SAMPLE_RATE   = 3'd5
   } csr_addr_type;

   // One operation per step of the sequence.
   typedef enum logic [2:0] {
      OP_NONE,
      OP_MUL_PERIOD,
      OP_MUL_RATE,
      OP_MUL_PROP,
      OP_MUL_INTEG,
      OP_MUL_DERIV,
      OP_ACC_LAST,
      OP_OUTPUT
   } op_type;

   typedef struct packed {
      logic   load;
      op_type op;
   } cmd_type;

endpackage

// ===== rtl/ppid_ctrl.sv =====
// ----------------------------------------------------------------------------
// Positional PID sequencer
// Steps one request through the shared multiplier and owns both handshakes.
// ----------------------------------------------------------------------------
module ppid_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output ppid_pkg::cmd_type cmd
);
   import ppid_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_PERIOD,
      ST_MUL_RATE,
      ST_MUL_PROP,
      ST_MUL_INTEG,
      ST_MUL_DERIV,
      ST_ACC_LAST,
      ST_OUTPUT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_fire;

   // The result register may be loaded once the previous result is gone.
   assign out_fire   = (state_ff == ST_OUTPUT) && (!rsp_valid_ff || rsp_tready);
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      cmd.load = (state_ff == ST_IDLE) && req_tvalid;
      case (state_ff)
         ST_MUL_PERIOD: cmd.op = OP_MUL_PERIOD;
         ST_MUL_RATE:   cmd.op = OP_MUL_RATE;
         ST_MUL_PROP:   cmd.op = OP_MUL_PROP;
         ST_MUL_INTEG:  cmd.op = OP_MUL_INTEG;
         ST_MUL_DERIV:  cmd.op = OP_MUL_DERIV;
         ST_ACC_LAST:   cmd.op = OP_ACC_LAST;
         ST_OUTPUT:     cmd.op = out_fire ? OP_OUTPUT : OP_NONE;
         default:       cmd.op = OP_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_MUL_PERIOD;
               end
            end
            ST_MUL_PERIOD: state_ff <= ST_MUL_RATE;
            ST_MUL_RATE:   state_ff <= ST_MUL_PROP;
            ST_MUL_PROP:   state_ff <= ST_MUL_INTEG;
            ST_MUL_INTEG:  state_ff <= ST_MUL_DERIV;
            ST_MUL_DERIV:  state_ff <= ST_ACC_LAST;
            ST_ACC_LAST:   state_ff <= ST_OUTPUT;
            ST_OUTPUT: begin
               if (out_fire) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/ppid_dp.sv =====
// ----------------------------------------------------------------------------
// Positional PID datapath
// Control registers, error, integrator and derivative state, one shared
// 33x33 signed multiplier with a registered product, and the term accumulator.
// ----------------------------------------------------------------------------
module ppid_dp #(
   parameter int FRAC_BITS = ppid_pkg::FRAC_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [ppid_pkg::CSR_ADDR_W-1:0]      csr_addr,
   input  logic [ppid_pkg::DATA_W-1:0]          csr_wdata,
   input  ppid_pkg::cmd_type                    cmd,
   input  logic [2*ppid_pkg::DATA_W-1:0]        req_tdata,
   output logic [ppid_pkg::DATA_W-1:0]          rsp_tdata
);
   import ppid_pkg::*;

   localparam logic signed [PROD_W-1:0] MAX32 = PROD_W'(64'sd2147483647);
   localparam logic signed [PROD_W-1:0] MIN32 = -PROD_W'(64'sd2147483648);

   function automatic logic signed [DATA_W-1:0] sat32(input logic signed [PROD_W-1:0] v);
      logic signed [DATA_W-1:0] r;
      if (v > MAX32) begin
         r = MAX32[DATA_W-1:0];
      end else if (v < MIN32) begin
         r = MIN32[DATA_W-1:0];
      end else begin
         r = v[DATA_W-1:0];
      end
      return r;
   endfunction

   // Control registers.
   logic signed [DATA_W-1:0]  prop_gain_ff, integ_gain_ff, deriv_gain_ff;
   logic        [CLAMP_W-1:0] integ_clamp_ff;
   logic        [TIME_W-1:0]  sample_period_ff, sample_rate_ff;

   // Loop state and working registers.
   logic signed [DATA_W-1:0] integrator_ff, integrator_in;
   logic signed [DATA_W-1:0] last_error_ff;
   logic signed [DATA_W-1:0] error_ff, deriv_ff;
   logic signed [OPER_W-1:0] diff_ff;
   logic signed [PROD_W-1:0] prod_ff, acc_ff;
   logic signed [DATA_W-1:0] rsp_data_ff;

   logic signed [DATA_W:0]   raw_error;
   logic signed [OPER_W-1:0] mul_a, mul_b;
   logic signed [PROD_W-1:0] prod_in;
   logic signed [PROD_W-1:0] term;
   logic signed [PROD_W-1:0] integ_sum, clamp_pos;

   assign raw_error = $signed({req_tdata[DATA_W-1], req_tdata[DATA_W-1:0]})
                    - $signed({req_tdata[2*DATA_W-1], req_tdata[2*DATA_W-1:DATA_W]});

   always_comb begin
      case (cmd.op)
         OP_MUL_PERIOD: begin
            mul_a = OPER_W'(error_ff);
            mul_b = $signed({{(OPER_W-TIME_W){1'b0}}, sample_period_ff});
         end
         OP_MUL_RATE: begin
            mul_a = diff_ff;
            mul_b = $signed({{(OPER_W-TIME_W){1'b0}}, sample_rate_ff});
         end
         OP_MUL_PROP: begin
            mul_a = OPER_W'(error_ff);
            mul_b = OPER_W'(prop_gain_ff);
         end
         OP_MUL_INTEG: begin
            mul_a = OPER_W'(integrator_ff);
            mul_b = OPER_W'(integ_gain_ff);
         end
         OP_MUL_DERIV: begin
            mul_a = OPER_W'(deriv_ff);
            mul_b = OPER_W'(deriv_gain_ff);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in = mul_a * mul_b;
   assign term    = prod_ff >>> FRAC_BITS;

   // Integrator step and clamp to the symmetric bound.
   assign clamp_pos = $signed({{(PROD_W-CLAMP_W){1'b0}}, integ_clamp_ff});
   assign integ_sum = PROD_W'(integrator_ff) + (prod_ff >>> PERIOD_BITS);

   always_comb begin
      if (integ_sum > clamp_pos) begin
         integrator_in = clamp_pos[DATA_W-1:0];
      end else if (integ_sum < -clamp_pos) begin
         integrator_in = DATA_W'(-clamp_pos);
      end else begin
         integrator_in = integ_sum[DATA_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prop_gain_ff     <= '0;
         integ_gain_ff    <= '0;
         deriv_gain_ff    <= '0;
         integ_clamp_ff   <= '0;
         sample_period_ff <= TIME_W'(131);
         sample_rate_ff   <= TIME_W'(500);
      end else if (csr_we) begin
         case (csr_addr)
            REG_PROP_GAIN:     prop_gain_ff     <= csr_wdata;
            REG_INTEG_GAIN:    integ_gain_ff    <= csr_wdata;
            REG_DERIV_GAIN:    deriv_gain_ff    <= csr_wdata;
            REG_INTEG_CLAMP:   integ_clamp_ff   <= csr_wdata[CLAMP_W-1:0];
            REG_SAMPLE_PERIOD: sample_period_ff <= csr_wdata[TIME_W-1:0];
            REG_SAMPLE_RATE:   sample_rate_ff   <= csr_wdata[TIME_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         integrator_ff <= '0;
         last_error_ff <= '0;
      end else begin
         if (cmd.op == OP_MUL_PERIOD) begin
            last_error_ff <= error_ff;
         end
         if (cmd.op == OP_MUL_RATE) begin
            integrator_ff <= integrator_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         error_ff <= sat32(PROD_W'(raw_error));
      end
      prod_ff <= prod_in;
      case (cmd.op)
         OP_MUL_PERIOD: diff_ff <= OPER_W'(error_ff) - OPER_W'(last_error_ff);
         OP_MUL_PROP:   deriv_ff <= sat32(prod_ff);
         OP_MUL_INTEG:  acc_ff <= term;
         OP_MUL_DERIV:  acc_ff <= acc_ff + term;
         OP_ACC_LAST:   acc_ff <= acc_ff + term;
         OP_OUTPUT:     rsp_data_ff <= sat32(acc_ff);
         default: ;
      endcase
   end

   assign rsp_tdata = rsp_data_ff;

endmodule

// ===== rtl/positional_pid_controller_core.sv =====
// ----------------------------------------------------------------------------
// Positional PID controller core
// Signed fixed-point PID step with a clamped integrator, a first-difference
// derivative and a saturated drive output.
// ----------------------------------------------------------------------------
//
//   Port group   Direction   Contents
//   req_*        in          request: setpoint [31:0], measured [63:32]
//   rsp_*        out         response: drive [31:0]
//   csr_*        in          register write: index, 32-bit data
//
// After a request is accepted the sequencer runs five steps through the single
// shared multiplier, one step to add the last term and one to load the
// response register. The sequencer is idle again in the next cycle.
// One request is processed at a time; req_tready is high only while idle.
// A finished response that is not taken holds the sequencer in its last step.
// Reset is synchronous and active high; it clears the integrator, the stored
// error and the registers to their defaults (period 131, rate 500).
//
module positional_pid_controller_core #(
   parameter int FRAC_BITS = ppid_pkg::FRAC_BITS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*ppid_pkg::DATA_W-1:0]     req_tdata,   // setpoint, measured
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [ppid_pkg::DATA_W-1:0]       rsp_tdata,   // drive
   // Register write port.
   input  logic                              csr_we,
   input  logic [ppid_pkg::CSR_ADDR_W-1:0]   csr_addr,
   input  logic [ppid_pkg::DATA_W-1:0]       csr_wdata
);
   import ppid_pkg::*;

   // Command from the sequencer: a load strobe on acceptance and the
   // operation of the current step.
   cmd_type cmd;

   ppid_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath forms the error on acceptance, then the integrator update,
   // derivative, and the three gain products, summed and saturated.
   ppid_dp #(
      .FRAC_BITS (FRAC_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .rsp_tdata (rsp_tdata)
   );

endmodule

// ===== rtl/ppid_checker.sv =====
// ----------------------------------------------------------------------------
// Positional PID port checker
// Watches the top-level handshakes for sequencing and hold behavior.
// ----------------------------------------------------------------------------
module ppid_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [ppid_pkg::DATA_W-1:0]   rsp_tdata
);

   // A waiting response keeps its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   // After reset the block is idle with nothing to deliver.
   a_reset_idle: assert property (@(posedge clock)
      reset |=> req_tready && !rsp_tvalid)
      else $error("not idle after reset");

   // An accepted request closes the input, and it is still closed at the output step.
   a_busy_next: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("request accepted while busy");

   a_busy_end: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##7 !req_tready)
      else $error("sequence ended early");

   // A new response appears exactly as the sequencer returns to idle.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("response raised while busy");

endmodule

bind positional_pid_controller_core ppid_checker u_ppid_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

// ===== test/tb_positional_pid_controller_core.sv =====
// ----------------------------------------------------------------------------
// Positional PID controller core testbench
// Drives setpoint and measurement requests through the stream port under
// bursty sender traffic and a stalling receiver. It reprograms the gains,
// clamp, period and rate between phases while the core is idle. A bit-exact
// fixed-point model of the controller predicts each drive value, and every
// response is compared with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module tb_positional_pid_controller_core;
   timeunit 1ns;
   timeprecision 1ps;

   import ppid_pkg::*;

   localparam int CLK_HALF      = 2;
   localparam int RESET_CYCLES  = 11;
   // Settling wait, in clock cycles, used once the core has no work left.
   localparam int STEP_LATENCY  = 8;
   localparam int CYCLE_LIMIT   = 600000;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int PHASES        = 16;
   localparam int LONG_HOLD     = 400;
   localparam int FRAC          = FRAC_BITS_DEF;

   localparam logic [DATA_W-1:0] Q_MAX = 32'h7FFF_FFFF;
   localparam logic [DATA_W-1:0] Q_MIN = 32'h8000_0000;
   localparam logic [DATA_W-1:0] Q_ONE = 32'h0001_0000;

   // Indexes outside the register map; writes to them must change nothing.
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_A = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_SPARE_B = 3'd7;

   // Ways in which the response side takes or refuses results.
   typedef enum int {
      RX_ALWAYS,
      RX_COIN,
      RX_SPARSE,
      RX_PERIODIC
   } rx_mode_type;

   // -------------------------------------------------------------------------
   // Drive prediction. The class keeps its own copy of the registers and of
   // the controller state, works every step in 64-bit signed arithmetic and
   // queues the drive values that the core has to return, in order.
   // -------------------------------------------------------------------------
   class drive_scoreboard;
      longint prop_gain;
      longint integ_gain;
      longint deriv_gain;
      longint integ_clamp;
      longint sample_period;
      longint sample_rate;
      longint integrator;
      longint last_error;
      logic [DATA_W-1:0] expected_drive[$];
      int failures;

      function new();
         prop_gain     = 0;
         integ_gain    = 0;
         deriv_gain    = 0;
         integ_clamp   = 0;
         sample_period = 131;
         sample_rate   = 500;
         integrator    = 0;
         last_error    = 0;
         failures      = 0;
      endfunction

      static function longint saturate(longint v);
         if (v > longint'(Q_MAX)) begin
            return longint'(Q_MAX);
         end
         if (v < -longint'(Q_MAX) - 1) begin
            return -longint'(Q_MAX) - 1;
         end
         return v;
      endfunction

      // Register writes mask their data to the register width; the spare
      // indexes fall through and leave everything as it was.
      function void write_register(logic [CSR_ADDR_W-1:0] index, logic [DATA_W-1:0] value);
         case (index)
            REG_PROP_GAIN:     prop_gain = longint'($signed(value));
            REG_INTEG_GAIN:    integ_gain = longint'($signed(value));
            REG_DERIV_GAIN:    deriv_gain = longint'($signed(value));
            REG_INTEG_CLAMP:   integ_clamp = value[CLAMP_W-1:0];
            REG_SAMPLE_PERIOD: sample_period = value[TIME_W-1:0];
            REG_SAMPLE_RATE:   sample_rate = value[TIME_W-1:0];
            default: ;
         endcase
      endfunction

      // One controller step for an accepted request. The shifts are
      // arithmetic on signed values, so they round toward minus infinity.
      function void note_request(logic [DATA_W-1:0] setpoint, logic [DATA_W-1:0] measured);
         longint err;
         longint acc;
         longint deriv;
         longint total;
         err = saturate(longint'($signed(setpoint)) - longint'($signed(measured)));
         acc = integrator + ((err * sample_period) >>> PERIOD_BITS);
         if (acc > integ_clamp) begin
            acc = integ_clamp;
         end
         if (acc < -integ_clamp) begin
            acc = -integ_clamp;
         end
         integrator = acc;
         deriv = saturate((err - last_error) * sample_rate);
         total = saturate(((err * prop_gain) >>> FRAC)
                        + ((integrator * integ_gain) >>> FRAC)
                        + ((deriv * deriv_gain) >>> FRAC));
         last_error = err;
         expected_drive.push_back(total[DATA_W-1:0]);
      endfunction

      function void check_drive(logic [DATA_W-1:0] actual);
         logic [DATA_W-1:0] wanted;
         if (expected_drive.size() == 0) begin
            $display("%0t: unexpected response, expected none, actual drive %h",
                     $time, actual);
            failures++;
         end else begin
            wanted = expected_drive.pop_front();
            if (actual !== wanted) begin
               $display("%0t: drive mismatch, expected %h, actual %h", $time, wanted, actual);
               failures++;
            end
         end
      endfunction

      function int pending();
         return expected_drive.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals. Every input of the core starts at a known value.
   // -------------------------------------------------------------------------
   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [2*DATA_W-1:0]     req_tdata  = '0;   // setpoint [31:0], measured [63:32]
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [DATA_W-1:0]       rsp_tdata;         // drive [31:0]
   logic                    csr_we     = 1'b0;
   logic [CSR_ADDR_W-1:0]   csr_addr   = '0;
   logic [DATA_W-1:0]       csr_wdata  = '0;

   drive_scoreboard sb = new();

   // Traffic shaping, changed by the main sequence from phase to phase.
   rx_mode_type rx_mode      = RX_ALWAYS;
   bit          hold_request = 1'b0;
   int          hold_left    = 0;
   int          rx_tick      = 0;
   int          burst_left   = 0;
   int          burst_max    = 1;
   int          gap_max      = 0;
   longint      cycles       = 0;

   // State of the tracking sequences: a setpoint that jumps now and then and
   // a measurement that closes in on it, as a real control loop would.
   logic signed [DATA_W-1:0] track_sp = '0;
   logic signed [DATA_W-1:0] track_ms = '0;

   positional_pid_controller_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always begin
      #CLK_HALF clock = 1'b1;
      #CLK_HALF clock = 1'b0;
   end

   // The run is bounded no matter what the core does.
   initial begin
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles >= CYCLE_LIMIT) begin
            $display("positional_pid_controller_core regression: fail");
            $finish;
         end
      end
   end

   // Responses are sampled at the rising edge, where tready was set at the falling
   // edge before it and tvalid still shows its value from before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_drive(rsp_tdata);
      end
   end

   // Response side. A long hold-off, when requested, is counted here on its
   // own so the sender keeps offering requests while the core is blocked;
   // otherwise the current stall pattern decides tready at each falling edge.
   initial begin
      forever begin
         @(negedge clock);
         rx_tick++;
         if (hold_request) begin
            hold_left    = LONG_HOLD;
            hold_request = 1'b0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               RX_ALWAYS:   rsp_tready <= 1'b1;
               RX_COIN:     rsp_tready <= 1'($urandom_range(0, 1));
               RX_SPARSE:   rsp_tready <= ($urandom_range(0, 3) == 0);
               RX_PERIODIC: rsp_tready <= ((rx_tick % 7) < 3);
               default:     rsp_tready <= 1'b1;
            endcase
         end
      end
   end

   // Offers one request and waits for the handshake. Within a burst tvalid
   // stays high into the next request; at the end of a burst a random gap
   // with tvalid low follows before the next burst starts.
   task automatic send_request(input logic [DATA_W-1:0] setpoint,
                               input logic [DATA_W-1:0] measured);
      int gap;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {measured, setpoint};
      do @(posedge clock); while (!req_tready);
      sb.note_request(setpoint, measured);
      if (burst_left > 0) begin
         burst_left--;
      end
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, burst_max);
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
   endtask

   // Stops offering and waits until every predicted drive has been returned,
   // then lets the core settle before anything is reprogrammed.
   task automatic wait_for_idle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (STEP_LATENCY) @(posedge clock);
   endtask

   // One register write: the enable is high for exactly one rising edge.
   task automatic write_reg(input logic [CSR_ADDR_W-1:0] index,
                            input logic [DATA_W-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      sb.write_register(index, value);
   endtask

   function automatic logic [DATA_W-1:0] random_gain();
      case ($urandom_range(0, 5))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return $urandom;
         default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
      endcase
   endfunction

   // The top bits above a register's width are filled at random; the core
   // has to ignore them.
   function automatic logic [DATA_W-1:0] random_clamp();
      logic [DATA_W-1:0] noise;
      noise = {1'($urandom_range(0, 1)), 31'b0};
      case ($urandom_range(0, 5))
         0: return noise;
         1: return 32'hFFFF_FFFF;
         2: return $urandom;
         default: return noise | $urandom_range(1, 32'h0400_0000);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] random_time();
      logic [DATA_W-1:0] noise;
      noise = {16'($urandom_range(0, 16'hFFFF)), 16'h0000};
      case ($urandom_range(0, 4))
         0: return noise | 32'd1;
         1: return noise | 32'h0000_FFFF;
         default: return noise | $urandom_range(1, 16'hFFFF);
      endcase
   endfunction

   function automatic logic [DATA_W-1:0] pick_corner();
      case ($urandom_range(0, 4))
         0: return Q_MAX;
         1: return Q_MIN;
         2: return '0;
         3: return Q_ONE;
         default: return $urandom;
      endcase
   endfunction

   // Mostly small errors and tracking sequences, so the integrator and the
   // sum work away from saturation; the rest is full-range noise and corners.
   task automatic send_random_request();
      logic [DATA_W-1:0] setpoint;
      logic [DATA_W-1:0] measured;
      case ($urandom_range(0, 9))
         0, 1: begin
            setpoint = $urandom;
            measured = $urandom;
         end
         2: begin
            setpoint = pick_corner();
            measured = pick_corner();
         end
         3, 4, 5: begin
            setpoint = $urandom;
            measured = setpoint + $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
         end
         default: begin
            if ($urandom_range(0, 15) == 0) begin
               track_sp = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
            end
            track_ms = track_ms + ((track_sp - track_ms) >>> 2)
                     + $signed($urandom_range(0, 32'h0000_2000)) - 32'sh0000_1000;
            setpoint = track_sp;
            measured = track_ms;
         end
      endcase
      send_request(setpoint, measured);
   endtask

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int phase;
      int n;
      int per_phase;
      int leftover;

      per_phase = RANDOM_ITEMS / PHASES;

      // Synchronous reset, held from the start and released once.
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // The directed part runs with the receiver always ready and the sender
      // back to back, so the corner cases are easy to follow in isolation.
      rx_mode   = RX_ALWAYS;
      burst_max = 1;
      gap_max   = 0;

      // With all gains at their reset value of zero the drive must be zero.
      send_request('0, '0);
      wait_for_idle();

      // Moderate gains, default period and rate still in force.
      write_reg(REG_PROP_GAIN, 32'h0001_8000);
      write_reg(REG_INTEG_GAIN, 32'h0000_4000);
      write_reg(REG_DERIV_GAIN, 32'h0000_0200);
      write_reg(REG_INTEG_CLAMP, 32'h0100_0000);
      send_request(Q_ONE, '0);
      // The error saturates both ways, and the jump between the two makes
      // the derivative saturate before its gain is applied.
      send_request(Q_MAX, Q_MIN);
      send_request(Q_MIN, Q_MAX);
      send_request(Q_MAX, Q_MAX);
      send_request(Q_MIN, Q_MIN);
      send_request(32'h1234_5678, 32'hFEDC_BA98);
      wait_for_idle();

      // A zero period leaves the integrator where it is, still clamped.
      write_reg(REG_SAMPLE_PERIOD, 32'h0000_0000);
      send_request(Q_ONE, '0);
      send_request(Q_MAX, '0);
      wait_for_idle();

      // A zero rate removes the derivative term entirely.
      write_reg(REG_SAMPLE_PERIOD, 32'h0000_FFFF);
      write_reg(REG_SAMPLE_RATE, 32'h0000_0000);
      send_request('0, Q_ONE);
      send_request(Q_MAX, Q_MIN);
      wait_for_idle();

      // A zero clamp pins the integrator at zero.
      write_reg(REG_SAMPLE_RATE, 32'h0000_FFFF);
      write_reg(REG_INTEG_CLAMP, 32'h0000_0000);
      send_request(Q_MAX, '0);
      send_request(Q_MIN, '0);
      wait_for_idle();

      // Let the integrator grow against the widest clamp, written with its
      // unused top bit set, then lower the clamp and see it bite at once.
      write_reg(REG_INTEG_CLAMP, 32'hFFFF_FFFF);
      send_request(Q_MAX, Q_MIN);
      send_request(Q_MAX, Q_MIN);
      send_request(Q_MAX, Q_MIN);
      wait_for_idle();
      write_reg(REG_INTEG_CLAMP, 32'h0000_8000);
      send_request('0, '0);
      send_request(Q_ONE, '0);
      wait_for_idle();

      // Extreme gains with the smallest period and rate drive the sum into
      // saturation in both directions.
      write_reg(REG_PROP_GAIN, Q_MAX);
      write_reg(REG_INTEG_GAIN, Q_MIN);
      write_reg(REG_DERIV_GAIN, Q_MIN);
      write_reg(REG_SAMPLE_PERIOD, 32'h0000_0001);
      write_reg(REG_SAMPLE_RATE, 32'h0000_0001);
      send_request(Q_MAX, Q_MIN);
      send_request(Q_MIN, Q_MAX);
      send_request(Q_MIN, '0);
      wait_for_idle();
      write_reg(REG_PROP_GAIN, Q_MIN);
      send_request(Q_MAX, Q_MIN);
      wait_for_idle();

      // Writes to indexes outside the map must not disturb anything.
      write_reg(REG_SPARE_A, $urandom);
      write_reg(REG_SPARE_B, $urandom);
      send_request(Q_ONE, '0);
      wait_for_idle();

      // Random phases: a fresh register setting, receiver pattern and burst
      // shape each time. Phase 0 runs with no idling on either side.
      for (phase = 0; phase < PHASES; phase++) begin
         wait_for_idle();
         write_reg(REG_PROP_GAIN, random_gain());
         write_reg(REG_INTEG_GAIN, random_gain());
         write_reg(REG_DERIV_GAIN, random_gain());
         write_reg(REG_INTEG_CLAMP, random_clamp());
         write_reg(REG_SAMPLE_PERIOD, random_time());
         write_reg(REG_SAMPLE_RATE, random_time());

         if (phase == 0) begin
            rx_mode   = RX_ALWAYS;
            burst_max = 1;
            gap_max   = 0;
         end else begin
            rx_mode   = rx_mode_type'($urandom_range(0, 3));
            burst_max = $urandom_range(1, 20);
            gap_max   = $urandom_range(0, 12);
         end
         burst_left = 0;

         // The receiver blocks for a long stretch while requests keep coming,
         // so the core holds its result and drops req_tready.
         if (phase == 1 || phase == PHASES - 2) begin
            hold_request = 1'b1;
         end

         for (n = 0; n < per_phase; n++) begin
            // Halfway through one phase the sender stops until every result
            // has come back, then resumes with the same setting.
            if (phase == 2 && n == per_phase / 2) begin
               wait_for_idle();
            end
            send_random_request();
         end
      end

      // Drain, keep watching for any stray response, then judge the run.
      wait_for_idle();
      repeat (4 * STEP_LATENCY) @(posedge clock);
      leftover = sb.pending();
      if (leftover != 0) begin
         $display("%0t: %0d drive values expected but never returned", $time, leftover);
      end
      if (sb.failures == 0 && leftover == 0) begin
         $display("positional_pid_controller_core regression: pass");
      end else begin
         $display("positional_pid_controller_core regression: fail");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/ppid_pkg.sv
rtl/ppid_ctrl.sv
rtl/ppid_dp.sv
rtl/positional_pid_controller_core.sv
rtl/ppid_checker.sv
test/tb_positional_pid_controller_core.sv
